// File: hw/rtl/timeline_region_split_table_core_macros.svh
// ----------------------------------------------------------------------------
// Timeline region split table assertion macros
// Shared property macros for the region table core.
// ----------------------------------------------------------------------------
`ifndef TIMELINE_REGION_SPLIT_TABLE_CORE_MACROS_SVH
`define TIMELINE_REGION_SPLIT_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RTSC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define RTSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/rtsc_pkg.sv
// ----------------------------------------------------------------------------
// Region table package
// Sizes, operation codes, row layout and palette for the region table core.
// ----------------------------------------------------------------------------
package rtsc_pkg;

   localparam int MAX_REGIONS     = 64;
   localparam int PALETTE_ENTRIES = 8;
   localparam int IDX_W           = $clog2(MAX_REGIONS);
   localparam int CNT_W           = $clog2(MAX_REGIONS + 1);
   localparam int TIME_W          = 24;
   localparam int TOL_W           = 16;
   localparam int IDENT_W         = 16;
   localparam int COLOUR_W        = 32;
   localparam int OUT_IDX_W       = 7;
   localparam int BTIME_W         = 25;

   localparam logic [2:0] KIND_ADD   = 3'd0;
   localparam logic [2:0] KIND_DEL   = 3'd1;
   localparam logic [2:0] KIND_MOVE  = 3'd2;
   localparam logic [2:0] KIND_QUERY = 3'd3;
   localparam logic [2:0] KIND_NEAR  = 3'd4;
   localparam logic [2:0] KIND_CLEAR = 3'd5;

   localparam logic REG_SEQ_END  = 1'b0;
   localparam logic REG_SNAP_TOL = 1'b1;

   localparam logic [IDENT_W-1:0] IDENT_MAX = '1;

   typedef struct packed {
      logic [TIME_W-1:0]   start_ms;
      logic [TIME_W-1:0]   end_ms;
      logic [IDENT_W-1:0]  ident;
      logic [COLOUR_W-1:0] colour;
   } row_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      row_type          row;
   } wr_type;

   localparam logic [COLOUR_W-1:0] PALETTE_ROM [16] = '{
      32'h402196F3, 32'h404CAF50, 32'h40FF9800, 32'h409C27B0,
      32'h40009688, 32'h40F44336, 32'h40607D8B, 32'h40FFC107,
      32'h402196F3, 32'h404CAF50, 32'h40FF9800, 32'h409C27B0,
      32'h40009688, 32'h40F44336, 32'h40607D8B, 32'h40FFC107
   };

   function automatic logic [COLOUR_W-1:0] colour_of(input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] m;
      m = n % CNT_W'(PALETTE_ENTRIES);
      return PALETTE_ROM[m[3:0]];
   endfunction

endpackage

// File: hw/rtl/rtsc_row_store.sv
// ----------------------------------------------------------------------------
// Region row store
// One-write, one-read memory of region rows with a registered read.
// ----------------------------------------------------------------------------
module rtsc_row_store (
   input  logic                    clock,
   input  rtsc_pkg::wr_type        wr,
   input  logic [rtsc_pkg::IDX_W-1:0] rd_addr,
   output rtsc_pkg::row_type       rd_row
);
   import rtsc_pkg::*;

   row_type mem [MAX_REGIONS];
   row_type rd_row_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.row;
      end
      rd_row_ff <= mem[rd_addr];
   end

   assign rd_row = rd_row_ff;

endmodule

// File: hw/rtl/timeline_region_split_table_core.sv
// ----------------------------------------------------------------------------
// Timeline region split table core
// Sorted table of timeline regions with add, delete, move, lookup, nearest
// boundary and clear operations, one result word per request word.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload
//  req_     in         tuser: kind[2:0]; tdata: time_ms[23:0], new_time_ms[47:24]
//  rsp_     out        tuser: applied; tdata: index, start, end, ident, colour,
//                      boundary time, region total (lowest bits first)
//  csr_     in         write enable, register index, 24-bit write data
//
// A request word goes straight to its result on a clear, an unused kind, a refused add
// or an operation on an empty table; otherwise the rows are walked one at a time
// through the single read port of the row store, and the search together with the
// row shift that follows it covers each row once.
// Reset clears the count and the sequence end register, sets the identifier counter
// to one and the snap tolerance to 100; the row store needs no clearing pass, as only
// rows below the count are read.
// A stalled result word holds in the output register; the next request word
// is taken once the previous one has been worked, even while its result waits.
//
module timeline_region_split_table_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // time_ms, new_time_ms
   input  logic [2:0]   req_tuser,   // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // region_index, region_start, region_end,
                                     // region_ident, region_colour,
                                     // boundary_time, region_total, pad
   output logic [0:0]   rsp_tuser,   // applied
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [23:0]  csr_wdata
);
   import rtsc_pkg::*;

   `include "timeline_region_split_table_core_macros.svh"

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_SHIFT, S_WR0, S_WR1, S_DONE
   } state_type;

   state_type             state_ff,  state_in;
   logic [2:0]            kind_ff,   kind_in;
   logic [TIME_W-1:0]     t_ff,      t_in;
   logic [TIME_W-1:0]     nt_ff,     nt_in;
   logic [CNT_W-1:0]      i_ff,      i_in;
   logic [IDX_W-1:0]      addr_ff,   addr_in;
   logic                  phase_ff,  phase_in;
   logic [IDX_W-1:0]      k_ff,      k_in;
   row_type               rowk_ff,   rowk_in;
   row_type               prev_ff,   prev_in;
   logic [TOL_W:0]        best_ff,   best_in;
   logic [CNT_W-1:0]      cnt_ff,    cnt_in;
   logic [IDENT_W-1:0]    nid_ff,    nid_in;
   logic [TIME_W-1:0]     seq_end_ff;
   logic [TOL_W-1:0]      tol_ff;

   logic                  res_app_ff, res_app_in;
   logic [OUT_IDX_W-1:0]  res_idx_ff, res_idx_in;
   row_type               res_row_ff, res_row_in;
   logic [BTIME_W-1:0]    res_bt_ff,  res_bt_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_app_ff,   rsp_app_in;
   logic [OUT_IDX_W-1:0]  rsp_idx_ff,   rsp_idx_in;
   row_type               rsp_row_ff,   rsp_row_in;
   logic [BTIME_W-1:0]    rsp_bt_ff,    rsp_bt_in;
   logic [CNT_W-1:0]      rsp_cnt_ff,   rsp_cnt_in;

   wr_type                wr;
   row_type               rd_row;

   logic                  hit_at;
   logic [TIME_W-1:0]     gap_ms;
   logic [TIME_W:0]       lo, hi, v0, v1;
   logic [TIME_W-1:0]     mv;
   logic [IDX_W-1:0]      k_dec, k_inc;
   logic [IDENT_W-1:0]    nid_next;
   logic                  first_add;

   rtsc_row_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (addr_ff),
      .rd_row  (rd_row)
   );

   // Helpers shared by the sequencer and the write path.
   always_comb begin
      hit_at    = (t_ff >= rd_row.start_ms) && (t_ff < rd_row.end_ms);
      gap_ms    = (rd_row.start_ms > t_ff) ? (rd_row.start_ms - t_ff)
                                           : (t_ff - rd_row.start_ms);
      lo        = {1'b0, prev_ff.start_ms} + (TIME_W+1)'(1);
      hi        = {1'b0, rowk_ff.end_ms} - (TIME_W+1)'(1);
      v0        = ({1'b0, nt_ff} > hi) ? hi : {1'b0, nt_ff};
      v1        = (v0 < lo) ? lo : v0;
      mv        = v1[TIME_W-1:0];
      k_dec     = k_ff - IDX_W'(1);
      k_inc     = k_ff + IDX_W'(1);
      nid_next  = (nid_ff < IDENT_MAX) ? (nid_ff + IDENT_W'(1)) : nid_ff;
      first_add = (cnt_ff == '0);
   end

   // Write path into the row store.
   always_comb begin
      wr = '0;
      case (state_ff)
         S_SHIFT: begin
            wr.en   = phase_ff;
            wr.addr = i_ff[IDX_W-1:0];
            wr.row  = rd_row;
         end
         S_WR0: begin
            wr.en = 1'b1;
            case (kind_ff)
               KIND_ADD: begin
                  if (first_add) begin
                     wr.addr = '0;
                     wr.row  = '{start_ms: '0, end_ms: t_ff, ident: nid_ff,
                                 colour: colour_of(CNT_W'(0))};
                  end else begin
                     wr.addr = k_inc;
                     wr.row  = '{start_ms: t_ff, end_ms: rowk_ff.end_ms, ident: nid_ff,
                                 colour: colour_of(cnt_ff)};
                  end
               end
               KIND_MOVE: begin
                  wr.addr = k_dec;
                  wr.row  = '{start_ms: prev_ff.start_ms, end_ms: mv,
                              ident: prev_ff.ident, colour: prev_ff.colour};
               end
               default: begin
                  wr.addr = k_dec;
                  wr.row  = '{start_ms: prev_ff.start_ms, end_ms: rowk_ff.end_ms,
                              ident: prev_ff.ident, colour: prev_ff.colour};
               end
            endcase
         end
         S_WR1: begin
            wr.en = 1'b1;
            case (kind_ff)
               KIND_ADD: begin
                  if (first_add) begin
                     wr.addr = IDX_W'(1);
                     wr.row  = '{start_ms: t_ff, end_ms: seq_end_ff, ident: nid_ff,
                                 colour: colour_of(CNT_W'(1))};
                  end else begin
                     wr.addr = k_ff;
                     wr.row  = '{start_ms: rowk_ff.start_ms, end_ms: t_ff,
                                 ident: rowk_ff.ident, colour: rowk_ff.colour};
                  end
               end
               default: begin
                  wr.addr = k_ff;
                  wr.row  = '{start_ms: mv, end_ms: rowk_ff.end_ms,
                              ident: rowk_ff.ident, colour: rowk_ff.colour};
               end
            endcase
         end
         default: begin
            wr = '0;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      t_in         = t_ff;
      nt_in        = nt_ff;
      i_in         = i_ff;
      addr_in      = addr_ff;
      phase_in     = phase_ff;
      k_in         = k_ff;
      rowk_in      = rowk_ff;
      prev_in      = prev_ff;
      best_in      = best_ff;
      cnt_in       = cnt_ff;
      nid_in       = nid_ff;
      res_app_in   = res_app_ff;
      res_idx_in   = res_idx_ff;
      res_row_in   = res_row_ff;
      res_bt_in    = res_bt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_app_in   = rsp_app_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_bt_in    = rsp_bt_ff;
      rsp_cnt_in   = rsp_cnt_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in    = req_tuser;
               t_in       = req_tdata[23:0];
               nt_in      = req_tdata[47:24];
               i_in       = '0;
               addr_in    = '0;
               phase_in   = 1'b0;
               best_in    = {1'b0, tol_ff} + (TOL_W+1)'(1);
               res_app_in = 1'b0;
               res_idx_in = '1;
               res_row_in = '0;
               res_bt_in  = '1;
               state_in   = S_DONE;
               case (req_tuser)
                  KIND_ADD: begin
                     if (cnt_ff == '0) begin
                        if ((req_tdata[23:0] != '0) && (req_tdata[23:0] < seq_end_ff)) begin
                           state_in = S_WR0;
                        end
                     end else if (cnt_ff < CNT_W'(MAX_REGIONS)) begin
                        state_in = S_SCAN;
                     end
                  end
                  KIND_DEL, KIND_MOVE, KIND_NEAR: begin
                     if (cnt_ff >= CNT_W'(2)) begin
                        state_in = S_SCAN;
                     end
                  end
                  KIND_QUERY: begin
                     if (cnt_ff != '0) begin
                        state_in = S_SCAN;
                     end
                  end
                  KIND_CLEAR: begin
                     res_app_in = (cnt_ff != '0);
                     cnt_in     = '0;
                     nid_in     = IDENT_W'(1);
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               prev_in  = rd_row;
               if (i_ff + CNT_W'(1) == cnt_ff) begin
                  state_in = S_DONE;
               end else begin
                  i_in    = i_ff + CNT_W'(1);
                  addr_in = IDX_W'(i_ff + CNT_W'(1));
               end
               case (kind_ff)
                  KIND_ADD: begin
                     if (hit_at) begin
                        state_in = S_DONE;
                        if (t_ff != rd_row.start_ms) begin
                           k_in    = i_ff[IDX_W-1:0];
                           rowk_in = rd_row;
                           if (i_ff + CNT_W'(1) == cnt_ff) begin
                              state_in = S_WR0;
                           end else begin
                              state_in = S_SHIFT;
                              i_in     = cnt_ff;
                              addr_in  = IDX_W'(cnt_ff - CNT_W'(1));
                           end
                        end
                     end
                  end
                  KIND_QUERY: begin
                     if (hit_at) begin
                        state_in   = S_DONE;
                        res_app_in = 1'b1;
                        res_idx_in = OUT_IDX_W'(i_ff);
                        res_row_in = rd_row;
                     end
                  end
                  KIND_DEL, KIND_MOVE: begin
                     if ((i_ff != '0) && (rd_row.start_ms == t_ff)) begin
                        state_in = S_WR0;
                        prev_in  = prev_ff;
                        k_in     = i_ff[IDX_W-1:0];
                        rowk_in  = rd_row;
                     end
                  end
                  KIND_NEAR: begin
                     if ((i_ff != '0) && (gap_ms < TIME_W'(best_ff))) begin
                        best_in    = best_ff;
                        best_in    = gap_ms[TOL_W:0];
                        res_app_in = 1'b1;
                        res_idx_in = OUT_IDX_W'(i_ff);
                        res_row_in = rd_row;
                        res_bt_in  = {1'b0, rd_row.start_ms};
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_SHIFT: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (kind_ff == KIND_ADD) begin
                  // Rows move up by one, from the top down to the split point.
                  if (i_ff == {1'b0, k_ff} + CNT_W'(2)) begin
                     state_in = S_WR0;
                  end else begin
                     i_in    = i_ff - CNT_W'(1);
                     addr_in = IDX_W'(i_ff - CNT_W'(2));
                  end
               end else begin
                  // Rows move down by one, from the deleted row to the top.
                  if (i_ff + CNT_W'(2) == cnt_ff) begin
                     state_in = S_DONE;
                     res_app_in = 1'b1;
                     if (cnt_ff - CNT_W'(1) <= CNT_W'(1)) begin
                        cnt_in     = '0;
                        res_idx_in = '1;
                        res_row_in = '0;
                     end else begin
                        cnt_in     = cnt_ff - CNT_W'(1);
                        res_idx_in = OUT_IDX_W'(k_dec);
                     end
                  end else begin
                     i_in    = i_ff + CNT_W'(1);
                     addr_in = IDX_W'(i_ff + CNT_W'(2));
                  end
               end
            end
         end

         S_WR0: begin
            case (kind_ff)
               KIND_ADD: begin
                  nid_in   = nid_next;
                  state_in = S_WR1;
                  if (first_add) begin
                     res_row_in = wr.row;
                  end
               end
               KIND_MOVE: begin
                  state_in = S_WR1;
               end
               default: begin
                  res_row_in = wr.row;
                  if ({1'b0, k_ff} + CNT_W'(1) < cnt_ff) begin
                     state_in = S_SHIFT;
                     phase_in = 1'b0;
                     i_in     = {1'b0, k_ff};
                     addr_in  = k_inc;
                  end else begin
                     state_in   = S_DONE;
                     res_app_in = 1'b1;
                     if (cnt_ff - CNT_W'(1) <= CNT_W'(1)) begin
                        cnt_in     = '0;
                        res_idx_in = '1;
                        res_row_in = '0;
                     end else begin
                        cnt_in     = cnt_ff - CNT_W'(1);
                        res_idx_in = OUT_IDX_W'(k_dec);
                     end
                  end
               end
            endcase
         end

         S_WR1: begin
            state_in   = S_DONE;
            res_app_in = 1'b1;
            case (kind_ff)
               KIND_ADD: begin
                  if (first_add) begin
                     // The second region of a first split takes its own identifier.
                     nid_in     = nid_next;
                     cnt_in     = CNT_W'(2);
                     res_idx_in = '0;
                  end else begin
                     cnt_in     = cnt_ff + CNT_W'(1);
                     res_idx_in = OUT_IDX_W'(k_ff);
                     res_row_in = wr.row;
                  end
               end
               default: begin
                  res_idx_in = OUT_IDX_W'(k_ff);
                  res_row_in = wr.row;
               end
            endcase
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_app_in   = res_app_ff;
               rsp_idx_in   = res_idx_ff;
               rsp_row_in   = res_row_ff;
               rsp_bt_in    = res_bt_ff;
               rsp_cnt_in   = cnt_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         nid_ff       <= IDENT_W'(1);
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seq_end_ff   <= '0;
         tol_ff       <= TOL_W'(100);
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         nid_ff       <= nid_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_SEQ_END:  seq_end_ff <= csr_wdata;
               REG_SNAP_TOL: tol_ff     <= csr_wdata[TOL_W-1:0];
               default:      seq_end_ff <= seq_end_ff;
            endcase
         end
      end
      kind_ff    <= kind_in;
      t_ff       <= t_in;
      nt_ff      <= nt_in;
      i_ff       <= i_in;
      addr_ff    <= addr_in;
      k_ff       <= k_in;
      rowk_ff    <= rowk_in;
      prev_ff    <= prev_in;
      best_ff    <= best_in;
      res_app_ff <= res_app_in;
      res_idx_ff <= res_idx_in;
      res_row_ff <= res_row_in;
      res_bt_ff  <= res_bt_in;
      rsp_app_ff <= rsp_app_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_row_ff <= rsp_row_in;
      rsp_bt_ff  <= rsp_bt_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_app_ff;
   assign rsp_tdata  = {1'b0, rsp_cnt_ff, rsp_bt_ff, rsp_row_ff.colour, rsp_row_ff.ident,
                        rsp_row_ff.end_ms, rsp_row_ff.start_ms, rsp_idx_ff};

   // The table never holds a single region and never more than it can.
   `RTSC_ASSERT_NOW(a_count_legal, clock, reset, 1'b1,
      (cnt_ff != CNT_W'(1)) && (cnt_ff <= CNT_W'(MAX_REGIONS)), "illegal region count")
   // An accepted request word always starts work.
   `RTSC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready,
      state_ff != S_IDLE, "request accepted but sequencer idle")
   // The store is only written by the shift and the final row writes.
   `RTSC_ASSERT_NOW(a_write_states, clock, reset, wr.en,
      (state_ff == S_SHIFT) || (state_ff == S_WR0) || (state_ff == S_WR1),
      "row store written outside a write step")
   // The identifier counter never wraps to zero.
   `RTSC_ASSERT_NOW(a_ident_nonzero, clock, reset, 1'b1, nid_ff != '0,
      "identifier counter reached zero")

endmodule

// File: tb/timeline_region_split_table_core_check.sv
// ----------------------------------------------------------------------------
// Region table result checker
// Watches the request, result and register channels, keeps its own copy of
// the region table and compares every result word with the predicted one.
// ----------------------------------------------------------------------------
module timeline_region_split_table_core_check
   import rtsc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [47:0]  req_tdata,
   input  logic [2:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [135:0] rsp_tdata,
   input  logic [0:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [23:0]  csr_wdata,
   output int           fail_count,
   output int           outstanding
);

   // Laid out as on the result ports: applied on top, the index lowest.
   typedef struct packed {
      logic          applied;
      logic [6:0]    region_total;
      logic [24:0]   boundary_time;
      logic [31:0]   region_colour;
      logic [15:0]   region_ident;
      logic [23:0]   region_end;
      logic [23:0]   region_start;
      logic [6:0]    region_index;
   } outcome_type;

   logic [23:0] seq_end;
   logic [15:0] snap_tol;
   logic [23:0] row_start  [MAX_REGIONS];
   logic [23:0] row_end    [MAX_REGIONS];
   logic [15:0] row_ident  [MAX_REGIONS];
   logic [31:0] row_colour [MAX_REGIONS];
   int          rows;
   logic [15:0] ident_next;
   outcome_type expected_q [$];

   function automatic logic [15:0] claim_ident();
      logic [15:0] id;
      id = ident_next;
      if (ident_next != IDENT_MAX) ident_next++;
      return id;
   endfunction

   function automatic int region_holding(logic [23:0] t);
      for (int i = 0; i < rows; i++)
         if (t >= row_start[i] && t < row_end[i]) return i;
      return -1;
   endfunction

   function automatic int boundary_row(logic [23:0] t);
      for (int i = 1; i < rows; i++)
         if (row_start[i] == t) return i;
      return -1;
   endfunction

   // Applies one request to the table copy and returns the result it causes.
   function automatic outcome_type apply_request(logic [2:0] kind, logic [23:0] t,
                                                 logic [23:0] nt);
      outcome_type r;
      int          k;
      int          hit;
      logic [24:0] lo, hi, v;
      logic [24:0] best, d;
      hit = -1;
      r = '0;
      r.boundary_time = '1;
      case (kind)
         KIND_ADD: begin
            if (rows == 0) begin
               if (t > 0 && t < seq_end) begin
                  row_start[0] = '0; row_end[0] = t;
                  row_ident[0] = claim_ident(); row_colour[0] = PALETTE_ROM[0];
                  row_start[1] = t; row_end[1] = seq_end;
                  row_ident[1] = claim_ident(); row_colour[1] = PALETTE_ROM[1];
                  rows = 2;
                  r.applied = 1'b1; hit = 0;
               end
            end else if (rows < MAX_REGIONS) begin
               k = region_holding(t);
               if (k >= 0 && t > row_start[k]) begin
                  for (int i = rows; i > k + 1; i--) begin
                     row_start[i] = row_start[i-1]; row_end[i] = row_end[i-1];
                     row_ident[i] = row_ident[i-1]; row_colour[i] = row_colour[i-1];
                  end
                  row_start[k+1]  = t;
                  row_end[k+1]    = row_end[k];
                  row_ident[k+1]  = claim_ident();
                  row_colour[k+1] = PALETTE_ROM[rows % PALETTE_ENTRIES];
                  row_end[k] = t;
                  rows++;
                  r.applied = 1'b1; hit = k;
               end
            end
         end
         KIND_DEL: begin
            k = boundary_row(t);
            if (k > 0) begin
               row_end[k-1] = row_end[k];
               for (int i = k; i + 1 < rows; i++) begin
                  row_start[i] = row_start[i+1]; row_end[i] = row_end[i+1];
                  row_ident[i] = row_ident[i+1]; row_colour[i] = row_colour[i+1];
               end
               rows--;
               if (rows <= 1) rows = 0;
               r.applied = 1'b1; hit = k - 1;
            end
         end
         KIND_MOVE: begin
            k = boundary_row(t);
            if (k > 0) begin
               lo = {1'b0, row_start[k-1]} + 25'd1;
               hi = {1'b0, row_end[k]} - 25'd1;
               v = {1'b0, nt};
               if (v > hi) v = hi;
               if (v < lo) v = lo;
               row_end[k-1] = v[23:0];
               row_start[k] = v[23:0];
               r.applied = 1'b1; hit = k;
            end
         end
         KIND_QUERY: begin
            hit = region_holding(t);
            r.applied = hit >= 0;
         end
         KIND_NEAR: begin
            if (rows >= 2) begin
               best = {9'd0, snap_tol} + 25'd1;
               for (int i = 1; i < rows; i++) begin
                  d = row_start[i] > t ? row_start[i] - t : t - row_start[i];
                  if (d < best) begin
                     best = d; hit = i;
                  end
               end
               if (hit >= 0) begin
                  r.applied = 1'b1;
                  r.boundary_time = {1'b0, row_start[hit]};
               end
            end
         end
         KIND_CLEAR: begin
            r.applied = rows > 0;
            rows = 0;
            ident_next = 16'd1;
         end
         default: ;
      endcase
      if (hit >= 0 && hit < rows) begin
         r.region_index  = 7'(hit);
         r.region_start  = row_start[hit];
         r.region_end    = row_end[hit];
         r.region_ident  = row_ident[hit];
         r.region_colour = row_colour[hit];
      end else begin
         r.region_index = '1;
      end
      r.region_total = 7'(rows);
      return r;
   endfunction

   outcome_type got;
   outcome_type want;

   assign outstanding = expected_q.size();
   assign got = {rsp_tuser[0], rsp_tdata[134:0]};

   always @(posedge clock) begin
      if (reset) begin
         seq_end    <= '0;
         snap_tol   <= 16'd100;
         rows       = 0;
         ident_next = 16'd1;
         fail_count <= 0;
         expected_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == REG_SEQ_END) seq_end <= csr_wdata;
            else snap_tol <= csr_wdata[15:0];
         end
         if (req_tvalid && req_tready)
            expected_q.insert(expected_q.size(),
                              apply_request(req_tuser, req_tdata[23:0],
                                            req_tdata[47:24]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result word %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display({"mismatch: applied %0d/%0d index %h/%h start %h/%h ",
                               "end %h/%h ident %h/%h colour %h/%h btime %h/%h ",
                               "total %0d/%0d (expected/actual)"},
                              want.applied, got.applied, want.region_index,
                              got.region_index, want.region_start, got.region_start,
                              want.region_end, got.region_end, want.region_ident,
                              got.region_ident, want.region_colour, got.region_colour,
                              want.boundary_time, got.boundary_time,
                              want.region_total, got.region_total);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// File: tb/timeline_region_split_table_core_test.sv
// ----------------------------------------------------------------------------
// Region table core testbench
// Drives directed and random edit and query words into the region table core
// under random gaps and result stalls; a checker beside it predicts results.
// ----------------------------------------------------------------------------
module timeline_region_split_table_core_test;
   import rtsc_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [47:0]  req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_we = 1'b0;
   logic [0:0]   csr_index = '0;
   logic [23:0]  csr_wdata = '0;
   int           fail_count;
   int           outstanding;

   // Gap ceilings for each side; zero gives stretches with no idling at all.
   int           send_gap_max = 14;
   int           take_gap_max = 14;
   // Set once to make the receiver hold off while the sender keeps going.
   logic         hold_results = 1'b0;
   int           quiet_cycles = 0;
   // Boundary times recently offered, so that deletes, moves and nearest
   // searches mostly hit real boundaries.
   logic [23:0]  recent_times [$];

   always #5 clock = ~clock;

   timeline_region_split_table_core dut (.*);

   timeline_region_split_table_core_check checker_i (.*);

   // Result side: a random stall before each word, or a long hold-off once.
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_results) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_results = 1'b0;
         end
         gap = $urandom_range(0, take_gap_max);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Watchdog: the limit leaves a wide margin over the slowest word, the gaps and
   // the long hold-off.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 5000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_word(logic [2:0] kind, logic [23:0] t, logic [23:0] nt);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {nt, t};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (kind == KIND_ADD) begin
         recent_times.insert(recent_times.size(), t);
         if (recent_times.size() > 80) void'(recent_times.pop_front());
      end
   endtask

   // Waits for the table to drain before a register is written.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [23:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [23:0] pick_time(int span);
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 24'($urandom);
      if (r < 60 && recent_times.size() > 0)
         return recent_times[$urandom_range(0, recent_times.size() - 1)];
      return 24'($urandom_range(0, span));
   endfunction

   // One random phase: add_weight sets how often adds come, and clears can
   // be left out so that the table fills up to its limit.
   task automatic random_phase(int words, int span, int add_weight, bit clears);
      int          r;
      logic [2:0]  kind;
      logic [23:0] t;
      logic [23:0] nt;
      for (int n = 0; n < words; n++) begin
         if (n % 60 == 0) begin
            send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
            take_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
         end
         r = $urandom_range(0, 99);
         if (r < add_weight)                       kind = KIND_ADD;
         else if (r < add_weight + 12)             kind = KIND_DEL;
         else if (r < add_weight + 26)             kind = KIND_MOVE;
         else if (r < add_weight + 38)             kind = KIND_QUERY;
         else if (r < add_weight + 52)             kind = KIND_NEAR;
         else if (clears && r < add_weight + 55)   kind = KIND_CLEAR;
         else if (r < add_weight + 57)             kind = 3'($urandom_range(6, 7));
         else                                      kind = KIND_ADD;
         t = (kind == KIND_ADD) ? (($urandom_range(0, 9) == 0) ? 24'($urandom)
                                   : 24'($urandom_range(0, span)))
                                : pick_time(span);
         if (kind != KIND_ADD && $urandom_range(0, 3) == 0)
            t = t + 24'($urandom_range(0, 4)) - 24'd2;
         nt = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                          : 24'($urandom_range(0, span));
         send_word(kind, t, nt);
      end
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part on a sequence of 1000 ms with the reset tolerance.
      write_reg(REG_SEQ_END, 24'd1000);
      send_word(KIND_QUERY, 24'd5, '0);          // empty table lookup
      send_word(KIND_NEAR,  24'd5, '0);          // nearest with no regions
      send_word(KIND_DEL,   24'd5, '0);          // delete on empty table
      send_word(KIND_CLEAR, 24'd0, '0);          // clear on empty table
      send_word(KIND_ADD,   24'd0, '0);          // first add at zero is refused
      send_word(KIND_ADD,   24'd1000, '0);       // and at the sequence end
      send_word(KIND_ADD,   24'd500, '0);        // first add splits the range
      send_word(KIND_ADD,   24'd500, '0);        // existing start: no change
      send_word(KIND_ADD,   24'd250, '0);
      send_word(KIND_QUERY, 24'd0, '0);
      send_word(KIND_QUERY, 24'd999, '0);
      send_word(KIND_QUERY, 24'hFFFFFF, '0);     // beyond the last region
      send_word(KIND_NEAR,  24'd375, '0);        // equal distance to two boundaries, both outside the tolerance
      send_word(KIND_NEAR,  24'd800, '0);        // outside the tolerance
      send_word(KIND_MOVE,  24'd500, 24'd0);     // clamped to the lower bound
      send_word(KIND_MOVE,  24'd251, 24'hFFFFFF);// clamped to the upper bound
      send_word(KIND_MOVE,  24'd0, 24'd10);      // first start is no boundary
      send_word(KIND_DEL,   24'd250, '0);
      send_word(3'd6,       24'hFFFFFF, 24'hFFFFFF);
      send_word(3'd7,       24'd1, 24'd1);
      send_word(KIND_DEL,   24'd999, '0);        // last delete empties table
      send_word(KIND_ADD,   24'd600, '0);
      send_word(KIND_CLEAR, 24'd0, '0);

      // Random phases over several register settings, the extremes included.
      settle();
      write_reg(REG_SNAP_TOL, 24'd50);
      hold_results = 1'b1;                       // long stall on the results
      random_phase(190, 1100, 40, 1'b1);

      settle();
      write_reg(REG_SEQ_END, 24'd600);
      write_reg(REG_SNAP_TOL, 24'd0);
      random_phase(190, 650, 75, 1'b0);          // fill the table to its limit

      settle();
      write_reg(REG_SEQ_END, 24'hFFFFFF);
      write_reg(REG_SNAP_TOL, 24'hFFFF);
      random_phase(190, 4000, 40, 1'b1);

      settle();
      write_reg(REG_SEQ_END, 24'd0);             // first add always refused
      random_phase(40, 200, 40, 1'b1);

      settle();
      write_reg(REG_SEQ_END, 24'd3000);
      write_reg(REG_SNAP_TOL, 24'd20);
      random_phase(330, 3100, 45, 1'b1);

      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/rtsc_pkg.sv
hw/rtl/rtsc_row_store.sv
hw/rtl/timeline_region_split_table_core.sv
tb/timeline_region_split_table_core_check.sv
tb/timeline_region_split_table_core_test.sv
